>>> src/nvqe_pkg.sv
// ----------------------------------------------------------------------------
// nvqe_pkg: shared types and constants of the NVMe I/O queue command engine
// Word layouts, result kinds, opcodes and configuration register indexes.
// ----------------------------------------------------------------------------
package nvqe_pkg;

    // Page and block geometry
    localparam int PAGE_BYTES          = 4096;
    localparam int SHIFT_MIN           = 9;
    localparam int SHIFT_MAX           = 12;
    // Blocks in one page at the smallest block size
    localparam int BLOCKS_PER_PAGE_MAX = PAGE_BYTES >> SHIFT_MIN;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRP_LIST_BASE    = 2'd2;

    // Submission opcodes
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Input word kinds
    localparam logic CMD_START      = 1'b0;
    localparam logic CMD_COMPLETION = 1'b1;

    typedef enum logic [1:0] {
        KIND_SUBMIT = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_FAIL   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [3:0]  block_size_shift;
        logic [63:0] buffer_base;
        logic [63:0] prp_list_base;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic        write_request;
        logic [63:0] start_block;
        logic [31:0] block_total;
        logic        entry_phase;
        logic [14:0] entry_status;
    } in_word_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  opcode;
        logic [15:0] command_id;
        logic [63:0] chunk_lba;
        logic [6:0]  blocks_minus_one;
        logic [63:0] prp_first;
        logic [63:0] prp_second;
        logic [3:0]  sq_doorbell;
        logic        cq_doorbell_valid;
        logic [3:0]  cq_doorbell;
        logic [14:0] fail_status;
    } out_word_t;

endpackage

>>> src/nvqe_ifs.sv
// ----------------------------------------------------------------------------
// nvqe channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Request channel: start words and completion words
interface nvqe_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        write_request;
    logic [63:0] start_block;
    logic [31:0] block_total;
    logic        entry_phase;
    logic [14:0] entry_status;

    modport source (
        output valid, command, write_request, start_block, block_total,
               entry_phase, entry_status,
        input  ready
    );
    modport sink (
        input  valid, command, write_request, start_block, block_total,
               entry_phase, entry_status,
        output ready
    );
endinterface

// Result channel: submissions, done and fail words
interface nvqe_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  opcode;
    logic [15:0] command_id;
    logic [63:0] chunk_lba;
    logic [6:0]  blocks_minus_one;
    logic [63:0] prp_first;
    logic [63:0] prp_second;
    logic [3:0]  sq_doorbell;
    logic        cq_doorbell_valid;
    logic [3:0]  cq_doorbell;
    logic [14:0] fail_status;

    modport source (
        output valid, kind, opcode, command_id, chunk_lba, blocks_minus_one,
               prp_first, prp_second, sq_doorbell, cq_doorbell_valid,
               cq_doorbell, fail_status,
        input  ready
    );
    modport sink (
        input  valid, kind, opcode, command_id, chunk_lba, blocks_minus_one,
               prp_first, prp_second, sq_doorbell, cq_doorbell_valid,
               cq_doorbell, fail_status,
        output ready
    );
endinterface

// Configuration write channel
interface nvqe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/nvqe_io_queue_command_engine_unit.sv
// ----------------------------------------------------------------------------
// nvme_io_queue_command_engine_unit: host NVMe I/O queue pair engine
// Splits transfer requests into submission entries and consumes completions
// for one outstanding command.
//
//   channel   dir   handshake        carries
//   request   in    valid/ready      start or completion word
//   result    out   valid/ready      submit, done or fail word
//   cfg       in    valid/ready      register index and write data
//
// One word a cycle while no stall holds it: a request word is registered, decoded
// against the queue state in one pass and its result is registered in the output
// register when the request stage advances.
// A stalled result holds the request stage, whether or not the word in it
// gives a result; the request side stalls only while both stages are full.
// Reset clears queue pointers, phase (to one), command id and busy.
// ----------------------------------------------------------------------------
module nvme_io_queue_command_engine_unit #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int BUFFER_PAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    nvqe_cfg_if.sink    cfg,
    nvqe_req_if.sink    request,
    nvqe_res_if.source  result
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CHUNK_W = $clog2(BUFFER_PAGES * nvqe_pkg::BLOCKS_PER_PAGE_MAX + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    nvqe_pkg::cfg_t      cfg_q;

    // Request stage
    logic                in_valid_reg;
    logic                in_valid_next;
    nvqe_pkg::in_word_t  in_word_reg;

    // Queue state
    logic [PTR_W-1:0]    sq_tail_reg,  sq_tail_next;
    logic [PTR_W-1:0]    cq_head_reg,  cq_head_next;
    logic                cq_phase_reg, cq_phase_next;
    logic [15:0]         next_id_reg,  next_id_next;
    logic                busy_reg,     busy_next;
    logic                is_write_reg, is_write_next;
    logic [63:0]         next_lba_reg, next_lba_next;
    logic [31:0]         blocks_left_reg, blocks_left_next;

    // Result stage
    logic                out_valid_reg;
    logic                out_valid_next;
    nvqe_pkg::out_word_t out_word_reg;

    logic                advance;
    logic                is_start;
    logic                res_valid;
    logic                issue;
    nvqe_pkg::out_word_t res_word;
    logic [31:0]         sel_left;
    logic [63:0]         sel_lba;
    logic                sel_write;
    logic [CHUNK_W-1:0]  chunk_blocks;
    logic [63:0]         chunk_prp2;
    logic [PTR_W-1:0]    sq_tail_inc;
    logic [PTR_W-1:0]    cq_head_inc;
    logic [PTR_W+3:0]    sq_tail_ext;
    logic [PTR_W+3:0]    cq_head_ext;
    logic [CHUNK_W+6:0]  bm1_ext;

    nvqe_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Handshake between stages
    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !in_valid_reg || !out_valid_reg || result.ready;

    // Operand select: a start works on its own fields, a completion on state
    assign is_start  = (in_word_reg.command == nvqe_pkg::CMD_START);
    assign sel_left  = is_start ? in_word_reg.block_total   : blocks_left_reg;
    assign sel_lba   = is_start ? in_word_reg.start_block   : next_lba_reg;
    assign sel_write = is_start ? in_word_reg.write_request : is_write_reg;

    nvqe_chunk #(
        .BUFFER_PAGES (BUFFER_PAGES)
    ) u_chunk (
        .cfg          (cfg_q),
        .blocks_avail (sel_left),
        .chunk_blocks (chunk_blocks),
        .prp_second   (chunk_prp2)
    );

    // Ring pointer increments, modulo queue depth
    assign sq_tail_inc = (sq_tail_reg == PTR_LAST) ? '0 : sq_tail_reg + 1'b1;
    assign cq_head_inc = (cq_head_reg == PTR_LAST) ? '0 : cq_head_reg + 1'b1;
    assign sq_tail_ext = {4'b0, sq_tail_inc};
    assign cq_head_ext = {4'b0, cq_head_inc};
    assign bm1_ext     = {7'b0, chunk_blocks - CHUNK_W'(1)};

    // Word decode and state update
    always_comb
    begin
        sq_tail_next     = sq_tail_reg;
        cq_head_next     = cq_head_reg;
        cq_phase_next    = cq_phase_reg;
        next_id_next     = next_id_reg;
        busy_next        = busy_reg;
        is_write_next    = is_write_reg;
        next_lba_next    = next_lba_reg;
        blocks_left_next = blocks_left_reg;
        res_valid        = 1'b0;
        issue            = 1'b0;
        res_word         = '0;

        if (advance)
        begin
            priority if (is_start)
            begin
                if (!busy_reg)
                begin
                    res_valid        = 1'b1;
                    is_write_next    = in_word_reg.write_request;
                    next_lba_next    = in_word_reg.start_block;
                    blocks_left_next = in_word_reg.block_total;
                    if (in_word_reg.block_total == 32'd0)
                        res_word.kind = nvqe_pkg::KIND_DONE;
                    else
                        issue = 1'b1;
                end
            end
            else if (busy_reg && (in_word_reg.entry_phase == cq_phase_reg))
            begin
                res_valid                  = 1'b1;
                cq_head_next               = cq_head_inc;
                cq_phase_next              = cq_phase_reg ^ (cq_head_reg == PTR_LAST);
                res_word.cq_doorbell_valid = 1'b1;
                res_word.cq_doorbell       = cq_head_ext[3:0];
                priority if (in_word_reg.entry_status != 15'd0)
                begin
                    busy_next            = 1'b0;
                    res_word.kind        = nvqe_pkg::KIND_FAIL;
                    res_word.fail_status = in_word_reg.entry_status;
                end
                else if (blocks_left_reg != 32'd0)
                begin
                    issue = 1'b1;
                end
                else
                begin
                    busy_next     = 1'b0;
                    res_word.kind = nvqe_pkg::KIND_DONE;
                end
            end
            else
            begin
                res_valid = 1'b0;
            end

            // Issue the next chunk as a submission entry
            if (issue)
            begin
                busy_next                 = 1'b1;
                is_write_next             = sel_write;
                next_id_next              = next_id_reg + 16'd1;
                sq_tail_next              = sq_tail_inc;
                next_lba_next             = sel_lba + 64'(chunk_blocks);
                blocks_left_next          = sel_left - 32'(chunk_blocks);
                res_word.kind             = nvqe_pkg::KIND_SUBMIT;
                res_word.opcode           = sel_write ? nvqe_pkg::OP_WRITE : nvqe_pkg::OP_READ;
                res_word.command_id       = next_id_reg + 16'd1;
                res_word.chunk_lba        = sel_lba;
                res_word.blocks_minus_one = bm1_ext[6:0];
                res_word.prp_first        = cfg_q.buffer_base;
                res_word.prp_second       = chunk_prp2;
                res_word.sq_doorbell      = sq_tail_ext[3:0];
            end
        end
    end

    // Stage valid flags
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (request.valid && request.ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && res_valid)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    // Control and queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            sq_tail_reg     <= '0;
            cq_head_reg     <= '0;
            cq_phase_reg    <= 1'b1;
            next_id_reg     <= '0;
            busy_reg        <= 1'b0;
            is_write_reg    <= 1'b0;
            next_lba_reg    <= '0;
            blocks_left_reg <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            sq_tail_reg     <= sq_tail_next;
            cq_head_reg     <= cq_head_next;
            cq_phase_reg    <= cq_phase_next;
            next_id_reg     <= next_id_next;
            busy_reg        <= busy_next;
            is_write_reg    <= is_write_next;
            next_lba_reg    <= next_lba_next;
            blocks_left_reg <= blocks_left_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            in_word_reg.command       <= request.command;
            in_word_reg.write_request <= request.write_request;
            in_word_reg.start_block   <= request.start_block;
            in_word_reg.block_total   <= request.block_total;
            in_word_reg.entry_phase   <= request.entry_phase;
            in_word_reg.entry_status  <= request.entry_status;
        end
        if (advance && res_valid)
            out_word_reg <= res_word;
    end

    // Result port
    assign result.valid             = out_valid_reg;
    assign result.kind              = out_word_reg.kind;
    assign result.opcode            = out_word_reg.opcode;
    assign result.command_id        = out_word_reg.command_id;
    assign result.chunk_lba         = out_word_reg.chunk_lba;
    assign result.blocks_minus_one  = out_word_reg.blocks_minus_one;
    assign result.prp_first         = out_word_reg.prp_first;
    assign result.prp_second        = out_word_reg.prp_second;
    assign result.sq_doorbell       = out_word_reg.sq_doorbell;
    assign result.cq_doorbell_valid = out_word_reg.cq_doorbell_valid;
    assign result.cq_doorbell       = out_word_reg.cq_doorbell;
    assign result.fail_status       = out_word_reg.fail_status;

    // Each issued chunk takes the next command id
    a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> (next_id_reg == $past(next_id_reg) + 16'd1))
        else $error("command id did not step on issue");

    // Going idle always comes with a result word
    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(advance && res_valid))
        else $error("engine went idle without a result");

    // A fail word always follows a consumed completion
    a_fail_cq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_word_reg.kind == nvqe_pkg::KIND_FAIL))
            |-> out_word_reg.cq_doorbell_valid)
        else $error("fail word without CQ doorbell");

    // A blocked request word stays in its stage
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("request word lost while stalled");

endmodule

>>> src/nvqe_cfg_regs.sv
// ----------------------------------------------------------------------------
// nvqe_cfg_regs: configuration registers
// Holds block size shift, buffer base and PRP list base; always ready.
// ----------------------------------------------------------------------------
module nvqe_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    nvqe_cfg_if.sink           cfg,
    output nvqe_pkg::cfg_t     cfg_q
);

    nvqe_pkg::cfg_t cfg_reg;
    nvqe_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                nvqe_pkg::CFG_BLOCK_SIZE_SHIFT: cfg_next.block_size_shift = cfg.data[3:0];
                nvqe_pkg::CFG_BUFFER_BASE:      cfg_next.buffer_base      = cfg.data;
                nvqe_pkg::CFG_PRP_LIST_BASE:    cfg_next.prp_list_base    = cfg.data;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_size_shift <= 4'(nvqe_pkg::SHIFT_MIN);
            cfg_reg.buffer_base      <= '0;
            cfg_reg.prp_list_base    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/nvqe_chunk.sv
// ----------------------------------------------------------------------------
// nvqe_chunk: chunk sizing and PRP2 selection
// Clamps the request to the buffer size in blocks and picks the second PRP.
// ----------------------------------------------------------------------------
module nvqe_chunk #(
    parameter int BUFFER_PAGES = 16,
    localparam int CHUNK_W     = $clog2(BUFFER_PAGES * nvqe_pkg::BLOCKS_PER_PAGE_MAX + 1)
) (
    input  nvqe_pkg::cfg_t                 cfg,
    input  logic [31:0]                    blocks_avail,
    output logic [CHUNK_W-1:0]             chunk_blocks,
    output logic [63:0]                    prp_second
);

    localparam int PER_MAX = BUFFER_PAGES * nvqe_pkg::BLOCKS_PER_PAGE_MAX;
    localparam int CMP_W   = CHUNK_W + 5;
    localparam logic [CHUNK_W-1:0] PER_MAX_V = CHUNK_W'(PER_MAX);

    logic [1:0]         sh_off;
    logic [3:0]         blocks_per_page;
    logic [CHUNK_W-1:0] per_chunk;
    logic               one_page;
    logic               two_pages;

    // Effective block size, clamped to 512..4096 bytes
    always_comb
    begin
        priority if (cfg.block_size_shift < 4'(nvqe_pkg::SHIFT_MIN))
            sh_off = 2'd0;
        else if (cfg.block_size_shift > 4'(nvqe_pkg::SHIFT_MAX))
            sh_off = 2'd3;
        else
            sh_off = 2'(cfg.block_size_shift - 4'(nvqe_pkg::SHIFT_MIN));
    end

    assign blocks_per_page = 4'(nvqe_pkg::BLOCKS_PER_PAGE_MAX) >> sh_off;
    assign per_chunk       = PER_MAX_V >> sh_off;

    // Chunk length: remaining blocks, at most one buffer full
    assign chunk_blocks = (blocks_avail < 32'(per_chunk)) ?
                          blocks_avail[CHUNK_W-1:0] : per_chunk;

    // Pages spanned by the chunk
    assign one_page  = CMP_W'(chunk_blocks) <= CMP_W'(blocks_per_page);
    assign two_pages = CMP_W'(chunk_blocks) <= CMP_W'({blocks_per_page, 1'b0});

    always_comb
    begin
        priority if (one_page)
            prp_second = '0;
        else if (two_pages)
            prp_second = cfg.buffer_base + 64'(nvqe_pkg::PAGE_BYTES);
        else
            prp_second = cfg.prp_list_base;
    end

endmodule
